[src/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// payload field widths
	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int TCOL_W  = 7;
	localparam int TROW_W  = 5;
	localparam int RADDR_W = 11;
	localparam int OFFS_W  = 11;
	localparam int ATTR_W  = 8;
	localparam int CELL_W  = CHAR_W + ATTR_W;

	// character codes and reset attribute
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RST = 8'h07;
	localparam int                TAB_STEP = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_SET   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic sweep_start;
		logic sweep_en;
		logic load_out;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic need_scroll;
		logic sweep_last;
		logic out_free;
	} sts_t;

endpackage

[src/tcw_if.sv]
// ----------------------------------------------------------------------------
// tcw_if
// Handshake channels of the console writer: command, result and config.
// ----------------------------------------------------------------------------
interface tcw_req_if;
	import tcw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [CHAR_W-1:0]    character;
	logic [TCOL_W-1:0]    target_column;
	logic [TROW_W-1:0]    target_row;
	logic [RADDR_W-1:0]   read_address;

	modport source (output valid, command, character, target_column, target_row,
		read_address, input ready);
	modport sink (input valid, command, character, target_column, target_row,
		read_address, output ready);
endinterface

interface tcw_rsp_if;
	import tcw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [TCOL_W-1:0]    cursor_column;
	logic [TROW_W-1:0]    cursor_row;
	logic [OFFS_W-1:0]    cursor_offset;
	logic [CHAR_W-1:0]    cell_character;
	logic [ATTR_W-1:0]    cell_attribute;
	logic                 scrolled;

	modport source (output valid, cursor_column, cursor_row, cursor_offset,
		cell_character, cell_attribute, scrolled, input ready);
	modport sink (input valid, cursor_column, cursor_row, cursor_offset,
		cell_character, cell_attribute, scrolled, output ready);
endinterface

interface tcw_cfg_if;
	import tcw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ATTR_W-1:0]    data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[src/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: accept, execute, screen sweep and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tcw_pkg::sts_t sts,
	output tcw_pkg::ctl_t ctl
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctl.latch = in_valid;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = ST_DONE;
				case (sts.cmd)
					CMD_PUT: begin
						if (sts.need_scroll) begin
							ctl.sweep_start = 1'b1;
							state_d         = ST_SWEEP;
						end
					end
					CMD_CLEAR: begin
						ctl.sweep_start = 1'b1;
						state_d         = ST_SWEEP;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_SWEEP: begin
				ctl.sweep_en = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					in_ready     = 1'b1;
					ctl.latch    = in_valid;
					state_d      = in_valid ? ST_EXEC : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[src/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store, cursor, attribute, sweep counter and result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcw_pkg::ctl_t                 ctl,
	output tcw_pkg::sts_t                 sts,
	// command payload
	input  logic [tcw_pkg::CMD_W-1:0]     command,
	input  logic [tcw_pkg::CHAR_W-1:0]    character,
	input  logic [tcw_pkg::TCOL_W-1:0]    target_column,
	input  logic [tcw_pkg::TROW_W-1:0]    target_row,
	input  logic [tcw_pkg::RADDR_W-1:0]   read_address,
	// attribute write
	input  logic                          cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data,
	// result
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tcw_pkg::TCOL_W-1:0]    cursor_column,
	output logic [tcw_pkg::TROW_W-1:0]    cursor_row,
	output logic [tcw_pkg::OFFS_W-1:0]    cursor_offset,
	output logic [tcw_pkg::CHAR_W-1:0]    cell_character,
	output logic [tcw_pkg::ATTR_W-1:0]    cell_attribute,
	output logic                          scrolled
);
	import tcw_pkg::*;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COLX_W = $clog2(COLUMNS + TAB_STEP);
	localparam int ROWX_W = $clog2(ROWS + 1);

	// latched command
	cmd_t               cmd_q;
	logic [CHAR_W-1:0]  char_q;
	logic [TCOL_W-1:0]  tcol_q;
	logic [TROW_W-1:0]  trow_q;
	logic [RADDR_W-1:0] raddr_q;
	logic               addr_ok_q;

	// architectural state
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [ATTR_W-1:0]  attr_q;
	logic               scrolled_q;

	// sweep
	logic [ADDR_W-1:0]  cnt_q;
	logic               scroll_mode_q;
	logic               sweep_copy;
	logic               sw_valid_s1;
	logic               sw_copy_s1;
	logic [ADDR_W-1:0]  sw_addr_s1;

	// screen store
	logic [CELL_W-1:0]  mem [CELLS];
	logic [CELL_W-1:0]  rdata_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_wa;
	logic [CELL_W-1:0]  mem_wd;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_ra;
	logic [CELL_W-1:0]  blank;

	// put character
	logic [COLX_W-1:0]  pc;
	logic [ROWX_W-1:0]  pr;
	logic               printable;
	logic               need_scroll;
	logic [ADDR_W-1:0]  lin;

	// result register
	logic               out_valid_q;
	logic [TCOL_W-1:0]  ocol_q;
	logic [TROW_W-1:0]  orow_q;
	logic [OFFS_W-1:0]  ooff_q;
	logic [CHAR_W-1:0]  ochar_q;
	logic [ATTR_W-1:0]  oattr_q;
	logic               oscr_q;

	assign blank = {attr_q, CH_SPACE};
	assign lin   = ADDR_W'(row_q * COLUMNS + col_q);

	// cursor motion for put character
	always_comb begin
		pc        = COLX_W'(col_q);
		pr        = ROWX_W'(row_q);
		printable = 1'b0;
		case (char_q)
			CH_BS: begin
				if (col_q != '0) begin
					pc = pc - 1'b1;
				end else if (row_q != '0) begin
					pc = COLX_W'(COLUMNS - 1);
					pr = pr - 1'b1;
				end
			end
			CH_TAB: begin
				pc      = pc + COLX_W'(TAB_STEP);
				pc[2:0] = 3'b000;
			end
			CH_CR: begin
				pc = '0;
			end
			CH_LF: begin
				pr = pr + 1'b1;
			end
			default: begin
				if (char_q >= CH_SPACE && !char_q[CHAR_W-1]) begin
					printable = 1'b1;
					pc        = pc + 1'b1;
				end
			end
		endcase
		if (pc >= COLX_W'(COLUMNS)) begin
			pc = '0;
			pr = pr + 1'b1;
		end
		need_scroll = (pr >= ROWX_W'(ROWS));
		if (need_scroll) begin
			pr = ROWX_W'(ROWS - 1);
		end
	end

	// sweep source: copy rows up on scroll, blank on bottom row and on clear
	assign sweep_copy = scroll_mode_q && (cnt_q < ADDR_W'(CELLS - COLUMNS));

	// store port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = lin;
		mem_wd = {attr_q, char_q};
		if (sw_valid_s1) begin
			mem_we = 1'b1;
			mem_wa = sw_addr_s1;
			mem_wd = sw_copy_s1 ? rdata_q : blank;
		end else if (ctl.exec && cmd_q == CMD_PUT && printable) begin
			mem_we = 1'b1;
		end
		mem_re = (ctl.exec && cmd_q == CMD_READ) || (ctl.sweep_en && sweep_copy);
		mem_ra = ctl.sweep_en ? cnt_q + ADDR_W'(COLUMNS) : ADDR_W'(raddr_q);
	end

	// screen store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	// command latch
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q     <= cmd_t'(command);
			char_q    <= character;
			tcol_q    <= target_column;
			trow_q    <= target_row;
			raddr_q   <= read_address;
			addr_ok_q <= 32'(read_address) < CELLS;
		end
	end

	// sweep counter and write stage
	always_ff @(posedge clk) begin
		if (ctl.sweep_start) begin
			cnt_q         <= '0;
			scroll_mode_q <= (cmd_q == CMD_PUT);
		end else if (ctl.sweep_en) begin
			cnt_q <= cnt_q + 1'b1;
		end
		sw_addr_s1 <= cnt_q;
		sw_copy_s1 <= sweep_copy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_valid_s1 <= 1'b0;
		end else begin
			sw_valid_s1 <= ctl.sweep_en;
		end
	end

	// cursor, attribute and scroll flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			attr_q     <= ATTR_RST;
			scrolled_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_data;
			end
			if (ctl.latch) begin
				scrolled_q <= 1'b0;
			end else if (ctl.exec) begin
				case (cmd_q)
					CMD_PUT: begin
						col_q      <= pc[COL_W-1:0];
						row_q      <= pr[ROW_W-1:0];
						scrolled_q <= need_scroll;
					end
					CMD_SET: begin
						col_q <= (tcol_q < COLUMNS) ? COL_W'(tcol_q) : COL_W'(COLUMNS - 1);
						row_q <= (trow_q < ROWS) ? ROW_W'(trow_q) : ROW_W'(ROWS - 1);
					end
					default: begin
						col_q <= col_q;
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			ocol_q  <= TCOL_W'(col_q);
			orow_q  <= TROW_W'(row_q);
			ooff_q  <= OFFS_W'(lin);
			ochar_q <= (cmd_q == CMD_READ && addr_ok_q) ? rdata_q[CHAR_W-1:0] : '0;
			oattr_q <= (cmd_q == CMD_READ && addr_ok_q) ? rdata_q[CELL_W-1:CHAR_W] : '0;
			oscr_q  <= scrolled_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// status back to the controller
	always_comb begin
		sts.cmd         = cmd_q;
		sts.need_scroll = need_scroll;
		sts.sweep_last  = (cnt_q == ADDR_W'(CELLS - 1));
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid      = out_valid_q;
	assign cursor_column  = ocol_q;
	assign cursor_row     = orow_q;
	assign cursor_offset  = ooff_q;
	assign cell_character = ochar_q;
	assign cell_attribute = oattr_q;
	assign scrolled       = oscr_q;

endmodule

[src/text_console_character_writer_unit.sv]
// An accepted command item passes an execute state and then a result load
// state, which registers the result; a scroll or a clear puts a sweep of the
// screen store between the two. The next item is taken in the result load
// state, after the registered store read; sweeps and a full result slot stall.
// Reset: cursor to the origin, attribute to 7, no result pending; screen
// contents are undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
// text_console_character_writer_unit
// Text-mode console: character/attribute screen store with cursor control.
// ----------------------------------------------------------------------------
module text_console_character_writer_unit #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	tcw_req_if.sink   req,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink   cfg
);
	import tcw_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// attribute register always takes writes
	assign cfg.ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.command        (req.command),
		.character      (req.character),
		.target_column  (req.target_column),
		.target_row     (req.target_row),
		.read_address   (req.read_address),
		.cfg_we         (cfg.valid),
		.cfg_data       (cfg.data),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.cursor_column  (rsp.cursor_column),
		.cursor_row     (rsp.cursor_row),
		.cursor_offset  (rsp.cursor_offset),
		.cell_character (rsp.cell_character),
		.cell_attribute (rsp.cell_attribute),
		.scrolled       (rsp.scrolled)
	);

	// no item is taken while the screen store is being swept
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !ctl.sweep_en)
		else $error("item accepted during screen sweep");

	// an accepted item is executed in the next cycle
	a_accept_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> ctl.exec)
		else $error("accepted item not executed");

	// reported cursor stays on the screen
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (32'(rsp.cursor_column) < COLUMNS) && (32'(rsp.cursor_row) < ROWS))
		else $error("cursor outside the screen");

	// a result is only loaded when the output slot is free
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!rsp.valid || rsp.ready))
		else $error("result overwritten before it was taken");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console character writer. Commands go in
// over the request channel with random gaps, results come back under random
// stalls and are compared field by field with a cycle-free model of the
// screen store and cursor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tcw_pkg::*;

	localparam int COLS          = COLUMNS_DEF;
	localparam int ROWS          = ROWS_DEF;
	localparam int CELLS         = COLS * ROWS;
	localparam int RADDR_TOP     = 2 ** RADDR_W - 1;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int SWEEP_BUDGET  = 25;
	localparam logic [CHAR_W-1:0] PRINT_MAX = 8'h7F;
	localparam logic [CHAR_W-1:0] CONTROL_CODES [4] = '{CH_BS, CH_TAB, CH_CR, CH_LF};

	typedef struct packed {
		logic [TCOL_W-1:0] column;
		logic [TROW_W-1:0] row;
		logic [OFFS_W-1:0] offset;
		logic [CHAR_W-1:0] cell_char;
		logic [ATTR_W-1:0] cell_attr;
		logic              scrolled;
	} console_report_t;

	logic clk;
	logic arst_n;

	tcw_req_if cmd_ch ();
	tcw_rsp_if res_ch ();
	tcw_cfg_if attr_ch ();

	text_console_character_writer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd_ch),
		.rsp    (res_ch),
		.cfg    (attr_ch)
	);

	// screen and cursor as the block should hold them
	logic [CELL_W-1:0] screen_mem [CELLS];
	bit                screen_known [CELLS];
	int                cur_col = 0;
	int                cur_row = 0;
	logic [ATTR_W-1:0] attr_reg = ATTR_RST;
	int                last_put_pos = -1;

	console_report_t awaited_reports [$];
	int              error_count = 0;
	int              cycle_count = 0;
	int              stall_left = 0;
	int              sweeps_left = SWEEP_BUDGET;
	bit              no_idle = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// cursor motion of one put character, returns 1 on row overflow
	function automatic bit step_cursor(input logic [CHAR_W-1:0] code, inout int col,
		inout int row);
		case (code)
			CH_BS: begin
				if (col != 0) begin
					col--;
				end else if (row != 0) begin
					col = COLS - 1;
					row--;
				end
			end
			CH_TAB: col = col + TAB_STEP - (col % TAB_STEP);
			CH_CR: col = 0;
			CH_LF: row++;
			default: begin
				if (code >= CH_SPACE && code <= PRINT_MAX)
					col++;
			end
		endcase
		if (col >= COLS) begin
			col = 0;
			row++;
		end
		if (row >= ROWS) begin
			row = ROWS - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// apply one command to the screen model and form its report
	function automatic console_report_t apply_console_command(cmd_t cmd,
		logic [CHAR_W-1:0] code, logic [TCOL_W-1:0] tcol, logic [TROW_W-1:0] trow,
		logic [RADDR_W-1:0] addr);
		console_report_t rep;
		int pos;
		rep = '0;
		case (cmd)
			CMD_PUT: begin
				if (code >= CH_SPACE && code <= PRINT_MAX) begin
					pos = cur_row * COLS + cur_col;
					screen_mem[pos]   = {attr_reg, code};
					screen_known[pos] = 1'b1;
					last_put_pos      = pos;
				end
				if (step_cursor(code, cur_col, cur_row)) begin
					// move all rows up, blank the bottom row
					for (int i = 0; i < CELLS - COLS; i++) begin
						screen_mem[i]   = screen_mem[i + COLS];
						screen_known[i] = screen_known[i + COLS];
					end
					for (int i = CELLS - COLS; i < CELLS; i++) begin
						screen_mem[i]   = {attr_reg, CH_SPACE};
						screen_known[i] = 1'b1;
					end
					last_put_pos -= COLS;
					rep.scrolled = 1'b1;
				end
			end
			CMD_SET: begin
				cur_col = (tcol < COLS) ? int'(tcol) : COLS - 1;
				cur_row = (trow < ROWS) ? int'(trow) : ROWS - 1;
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					screen_mem[i]   = {attr_reg, CH_SPACE};
					screen_known[i] = 1'b1;
				end
			end
			CMD_READ: begin
				if (addr < CELLS) begin
					rep.cell_char = screen_mem[addr][CHAR_W-1:0];
					rep.cell_attr = screen_mem[addr][CELL_W-1:CHAR_W];
				end
			end
		endcase
		rep.column = TCOL_W'(cur_col);
		rep.row    = TROW_W'(cur_row);
		rep.offset = OFFS_W'(cur_row * COLS + cur_col);
		return rep;
	endfunction

	// send one command item and record what it should produce
	task automatic issue_command(cmd_t cmd, logic [CHAR_W-1:0] code,
		logic [TCOL_W-1:0] tcol, logic [TROW_W-1:0] trow, logic [RADDR_W-1:0] addr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid         <= 1'b1;
		cmd_ch.command       <= cmd;
		cmd_ch.character     <= code;
		cmd_ch.target_column <= tcol;
		cmd_ch.target_row    <= trow;
		cmd_ch.read_address  <= addr;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		awaited_reports.push_back(apply_console_command(cmd, code, tcol, trow, addr));
	endtask

	// stop sending and let every report come back
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_attribute(logic [ATTR_W-1:0] value);
		wait_idle();
		attr_ch.valid <= 1'b1;
		attr_ch.data  <= value;
		do
			@(posedge clk);
		while (!attr_ch.ready);
		attr_ch.valid <= 1'b0;
		attr_reg = value;
	endtask

	// result compare and receiver stalls
	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		console_report_t want;
		console_report_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.column    = res_ch.cursor_column;
			got.row       = res_ch.cursor_row;
			got.offset    = res_ch.cursor_offset;
			got.cell_char = res_ch.cell_character;
			got.cell_attr = res_ch.cell_attribute;
			got.scrolled  = res_ch.scrolled;
			if (awaited_reports.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual column %0d row %0d",
					$time, got.column, got.row);
				error_count++;
			end else begin
				want = awaited_reports.pop_front();
				check_field("cursor_column", 16'(want.column), 16'(got.column));
				check_field("cursor_row", 16'(want.row), 16'(got.row));
				check_field("cursor_offset", 16'(want.offset), 16'(got.offset));
				check_field("cell_character", 16'(want.cell_char), 16'(got.cell_char));
				check_field("cell_attribute", 16'(want.cell_attr), 16'(got.cell_attr));
				check_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else begin
			stall_left = pick_gap();
			res_ch.ready <= (stall_left == 0);
		end
	end

	// clear uses the reset attribute, reads at both ends and past the screen
	task automatic test_clear_and_read();
		issue_command(CMD_CLEAR, '0, '0, '0, '0);
		issue_command(CMD_READ, '0, '0, '0, 11'd0);
		issue_command(CMD_READ, '0, '0, '0, 11'(CELLS - 1));
		issue_command(CMD_READ, '0, '0, '0, 11'(RADDR_TOP));
	endtask

	// cursor placement, saturation of out of range targets
	task automatic test_set_cursor();
		no_idle = 1'b1;
		issue_command(CMD_SET, '0, 7'(COLS - 1), 5'(ROWS - 1), '0);
		issue_command(CMD_SET, '0, '1, '1, '0);
		issue_command(CMD_SET, '0, '0, '0, '0);
		no_idle = 1'b0;
	endtask

	// backspace, tab, cr, lf, printable limits and ignored codes
	task automatic test_control_codes();
		issue_command(CMD_PUT, 8'h41, '0, '0, '0);
		issue_command(CMD_READ, '0, '0, '0, 11'd0);
		issue_command(CMD_PUT, CH_BS, '0, '0, '0);
		// backspace at the origin stays put
		issue_command(CMD_PUT, CH_BS, '0, '0, '0);
		issue_command(CMD_PUT, PRINT_MAX, '0, '0, '0);
		issue_command(CMD_PUT, 8'h00, '0, '0, '0);
		issue_command(CMD_PUT, 8'h1F, '0, '0, '0);
		issue_command(CMD_PUT, 8'h80, '0, '0, '0);
		issue_command(CMD_PUT, 8'hFF, '0, '0, '0);
		issue_command(CMD_PUT, CH_TAB, '0, '0, '0);
		issue_command(CMD_PUT, CH_CR, '0, '0, '0);
		issue_command(CMD_PUT, CH_LF, '0, '0, '0);
	endtask

	// tab wrap, backspace to previous row, scroll by wrap and by newline
	task automatic test_wrap_and_scroll();
		issue_command(CMD_SET, '0, 7'(COLS - 3), 5'd3, '0);
		issue_command(CMD_PUT, CH_TAB, '0, '0, '0);
		issue_command(CMD_SET, '0, '0, 5'd5, '0);
		issue_command(CMD_PUT, CH_BS, '0, '0, '0);
		issue_command(CMD_SET, '0, 7'(COLS - 1), 5'(ROWS - 1), '0);
		issue_command(CMD_PUT, 8'h5A, '0, '0, '0);
		issue_command(CMD_READ, '0, '0, '0, 11'(CELLS - COLS - 1));
		issue_command(CMD_READ, '0, '0, '0, 11'(CELLS - COLS));
		issue_command(CMD_PUT, CH_LF, '0, '0, '0);
	endtask

	// one random command, steered away from unwritten cells and from
	// sweeps once this phase has used its share
	task automatic random_command();
		cmd_t               cmd;
		logic [CHAR_W-1:0]  code;
		logic [TCOL_W-1:0]  tcol;
		logic [TROW_W-1:0]  trow;
		logic [RADDR_W-1:0] addr;
		int                 roll;
		int                 col;
		int                 row;
		code = CHAR_W'($urandom);
		tcol = TCOL_W'($urandom);
		trow = TROW_W'($urandom);
		addr = RADDR_W'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			cmd  = CMD_PUT;
			roll = $urandom_range(0, 99);
			if (roll < 70)
				code = CHAR_W'($urandom_range(CH_SPACE, PRINT_MAX));
			else if (roll < 90)
				code = CONTROL_CODES[2'($urandom_range(0, 3))];
			col = cur_col;
			row = cur_row;
			if (step_cursor(code, col, row)) begin
				if (sweeps_left > 0) begin
					sweeps_left--;
				end else begin
					cmd  = CMD_SET;
					trow = TROW_W'($urandom_range(0, ROWS - 2));
				end
			end
		end else if (roll < 70) begin
			cmd = CMD_SET;
			if ($urandom_range(0, 4) != 0) begin
				tcol = TCOL_W'($urandom_range(0, COLS - 1));
				trow = TROW_W'($urandom_range(0, ROWS - 1));
			end
		end else if (roll < 73 && sweeps_left > 0) begin
			cmd = CMD_CLEAR;
			sweeps_left--;
		end else begin
			cmd = CMD_READ;
		end
		if (cmd == CMD_READ) begin
			roll = $urandom_range(0, 99);
			if (roll < 35 && last_put_pos >= 0)
				addr = RADDR_W'(last_put_pos);
			else if (roll < 85)
				addr = RADDR_W'($urandom_range(0, CELLS - 1));
			else
				addr = RADDR_W'($urandom_range(CELLS, RADDR_TOP));
			if (addr < CELLS && !screen_known[addr])
				addr = RADDR_W'($urandom_range(CELLS, RADDR_TOP));
		end
		issue_command(cmd, code, tcol, trow, addr);
	endtask

	// random traffic under one attribute setting
	task automatic test_random_traffic(logic [ATTR_W-1:0] attr, int count);
		write_attribute(attr);
		sweeps_left = SWEEP_BUDGET;
		for (int n = 0; n < count; n++) begin
			// some stretches run without gaps or stalls
			if (n % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			random_command();
		end
		no_idle = 1'b0;
	endtask

	// stimulus
	initial begin
		arst_n               = 1'b0;
		cmd_ch.valid         = 1'b0;
		cmd_ch.command       = CMD_PUT;
		cmd_ch.character     = '0;
		cmd_ch.target_column = '0;
		cmd_ch.target_row    = '0;
		cmd_ch.read_address  = '0;
		res_ch.ready         = 1'b0;
		attr_ch.valid        = 1'b0;
		attr_ch.data         = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_clear_and_read();
		test_set_cursor();
		test_control_codes();
		test_wrap_and_scroll();
		test_random_traffic(8'h00, 300);
		test_random_traffic(8'hFF, 300);
		test_random_traffic(8'($urandom), 320);
		test_random_traffic(8'($urandom), 320);
		test_random_traffic(8'($urandom), 310);

		wait_idle();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
